// ===== sv/rpn_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
// Holds field widths, the command opcodes and the status codes; depends on nothing.
package rpn_pkg;

   localparam int OPCODE_W = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = 4;

   // Command opcodes; codes 10 to 15 are unused and act as no-ops.
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH    = 4'd0,
      OP_POP     = 4'd1,
      OP_CLEAR   = 4'd2,
      OP_DISPLAY = 4'd3,
      OP_PEEK    = 4'd4,
      OP_ADD     = 4'd5,
      OP_MUL     = 4'd6,
      OP_SUB     = 4'd7,
      OP_DIV     = 4'd8,
      OP_POW     = 4'd9
   } opcode_type;

   // Per-command completion status.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_OVERFLOW = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FEW      = 3'd3,
      ST_MATH     = 3'd4
   } status_type;

endpackage

// ===== sv/rpn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the calculator's operand stack; no package dependencies.
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== sv/rpn_stack_calculator.sv =====
// RPN stack calculator: top level with the command sequencer and shared arithmetic.
// Depends on rpn_pkg and instantiates rpn_ram for the operand stack.
//
// The block takes one command at a time and drops req_ready until that command's
// last result has been loaded into the output register. Display sends one result
// per stack entry, top first, or a single result with no value for an empty stack.
// Add, subtract and multiply fetch both operands one after the other through the
// stack memory's single read port. Divide uses a restoring divider that settles
// one quotient bit per cycle, and power with a non-negative exponent uses one shared
// 32x32 multiplier doing a conditional multiply and a square for each of 31
// exponent bits. A stalled result channel holds the sequencer until the output
// register is free. After reset the stack is empty and no clearing pass is needed.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rpn_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [rpn_pkg::DATA_W-1:0]   req_operand,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rpn_pkg::DATA_W-1:0]   rsp_result_value,
   output logic                                rsp_has_value,
   output logic [rpn_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rpn_pkg::ENTRY_W-1:0]         rsp_entry_count,
   output logic                                rsp_last
);
   import rpn_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int STEP_W = 5;
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(STACK_DEPTH);
   localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(DATA_W - 1);
   localparam logic [STEP_W-1:0] POW_LAST   = STEP_W'(DATA_W - 2);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EMIT,
      S_SHOW,
      S_GET_B,
      S_GET_A,
      S_OPER,
      S_DIV,
      S_POW_M,
      S_POW_S,
      S_WB
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               single_ff, single_in;
   opcode_type         op_ff, op_in;
   logic [DATA_W-1:0]  a_ff, a_in;
   logic [DATA_W-1:0]  b_ff, b_in;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               neg_ff, neg_in;
   logic [DATA_W-1:0]  res_value_ff, res_value_in;
   logic               res_has_ff, res_has_in;
   status_type         res_status_ff, res_status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_has_ff, rsp_has_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic [DATA_W-1:0]  rd_data;

   logic [DATA_W-1:0]  mul_x, mul_y, prod;
   logic [DATA_W:0]    div_shift, div_diff;
   logic [DATA_W-1:0]  quo_next;
   logic               slot_free;
   logic               req_fire;

   // Operand stack storage; the read address follows the next index value.
   rpn_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_in),
      .rd_data(rd_data)
   );

   // Shared multiplier: operands chosen by the sequencer state.
   always_comb begin
      mul_x = a_ff;
      mul_y = b_ff;
      case (state_ff)
         S_POW_M: begin
            mul_x = acc_ff;
            mul_y = a_ff;
         end
         S_POW_S: begin
            mul_x = a_ff;
            mul_y = a_ff;
         end
         default: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
      endcase
   end
   assign prod = DATA_W'(mul_x * mul_y);

   // One restoring-division step: a_ff shifts out the dividend, acc_ff holds the remainder.
   assign div_shift = {acc_ff, a_ff[DATA_W-1]};
   assign div_diff  = div_shift - {1'b0, b_ff};
   assign quo_next  = {a_ff[DATA_W-2:0], ~div_diff[DATA_W]};

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Sequencer next-state and datapath logic.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      single_in     = single_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      res_value_in  = res_value_ff;
      res_has_in    = res_has_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data       = DATA_W'(req_operand);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // Default outcome: one result, no value, status ok.
               res_value_in  = '0;
               res_has_in    = 1'b0;
               res_status_in = ST_OK;
               state_in      = S_EMIT;
               case (req_opcode)
                  OP_PUSH: begin
                     if (count_ff >= FULL_COUNT) begin
                        res_status_in = ST_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_DISPLAY, OP_PEEK: begin
                     if (count_ff == '0) begin
                        if (req_opcode == OP_PEEK) begin
                           res_status_in = ST_EMPTY;
                        end
                     end else begin
                        idx_in    = ADDR_W'(count_ff - CNT_W'(1));
                        single_in = (req_opcode == OP_PEEK);
                        state_in  = S_SHOW;
                     end
                  end
                  OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_POW: begin
                     if (count_ff < CNT_W'(2)) begin
                        res_status_in = ST_FEW;
                     end else begin
                        op_in    = opcode_type'(req_opcode);
                        idx_in   = ADDR_W'(count_ff - CNT_W'(1));
                        state_in = S_GET_B;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_EMIT: begin
            // Single-result commands: move the result into the output register.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_has_in    = res_has_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = ENTRY_W'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_SHOW: begin
            // Display and peek: one stack entry per transfer, top first.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data;
               rsp_has_in    = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = ENTRY_W'(count_ff);
               rsp_last_in   = single_ff || (idx_ff == '0);
               if (single_ff || (idx_ff == '0)) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff - ADDR_W'(1);
               end
            end
         end

         S_GET_B: begin
            b_in     = rd_data;
            idx_in   = ADDR_W'(count_ff - CNT_W'(2));
            state_in = S_GET_A;
         end

         S_GET_A: begin
            a_in     = rd_data;
            state_in = S_OPER;
         end

         S_OPER: begin
            res_has_in    = 1'b1;
            res_status_in = ST_OK;
            step_in       = '0;
            state_in      = S_WB;
            if ((op_ff == OP_DIV && b_ff == '0) ||
                (op_ff == OP_POW && a_ff == '0 && b_ff[DATA_W-1])) begin
               // Divide by zero or zero to a negative power: stack is left alone.
               res_value_in  = '0;
               res_has_in    = 1'b0;
               res_status_in = ST_MATH;
               state_in      = S_EMIT;
            end else begin
               case (op_ff)
                  OP_ADD: res_value_in = a_ff + b_ff;
                  OP_SUB: res_value_in = a_ff - b_ff;
                  OP_MUL: res_value_in = prod;
                  OP_DIV: begin
                     // Divide magnitudes, fix the sign at the end.
                     a_in     = a_ff[DATA_W-1] ? (DATA_W'(0) - a_ff) : a_ff;
                     b_in     = b_ff[DATA_W-1] ? (DATA_W'(0) - b_ff) : b_ff;
                     neg_in   = a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
                     acc_in   = '0;
                     state_in = S_DIV;
                  end
                  OP_POW: begin
                     if (b_ff[DATA_W-1]) begin
                        // Negative exponent: only bases one and minus one survive.
                        if (a_ff == DATA_W'(1)) begin
                           res_value_in = DATA_W'(1);
                        end else if (a_ff == '1) begin
                           res_value_in = b_ff[0] ? '1 : DATA_W'(1);
                        end else begin
                           res_value_in = '0;
                        end
                     end else begin
                        acc_in   = DATA_W'(1);
                        state_in = S_POW_M;
                     end
                  end
                  default: res_value_in = '0;
               endcase
            end
         end

         S_DIV: begin
            a_in    = quo_next;
            acc_in  = div_diff[DATA_W] ? div_shift[DATA_W-1:0] : div_diff[DATA_W-1:0];
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) begin
               res_value_in = neg_ff ? (DATA_W'(0) - quo_next) : quo_next;
               state_in     = S_WB;
            end
         end

         S_POW_M: begin
            // Multiply the accumulator in when the current exponent bit is set.
            if (b_ff[0]) begin
               acc_in = prod;
            end
            state_in = S_POW_S;
         end

         S_POW_S: begin
            a_in    = prod;
            b_in    = b_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == POW_LAST) begin
               res_value_in = acc_ff;
               state_in     = S_WB;
            end else begin
               state_in = S_POW_M;
            end
         end

         S_WB: begin
            // Replace the two operands with the result.
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(count_ff - CNT_W'(2));
            wr_data  = res_value_ff;
            count_in = count_ff - CNT_W'(1);
            state_in = S_EMIT;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State, control and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      single_ff     <= single_in;
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      step_ff       <= step_in;
      neg_ff        <= neg_in;
      res_value_ff  <= res_value_in;
      res_has_ff    <= res_has_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_has_value    = rsp_has_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
